// ===== rtl/core/scc_pkg.sv =====
// Shared types, constants and register codes for the stable color classifier.
// No dependencies; every other file in rtl/core except scc_fifo uses this package.
`default_nettype none

package scc_pkg;

    localparam int NUM_PRESETS        = 5;
    localparam int NUM_CLASSES        = 6;
    localparam int SENSOR_CHANNELS    = 4;
    localparam int SESSION_LENGTH_DEF = 20;
    localparam int CHANNEL_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH        = 2;
    localparam int CFG_INDEX_BITS     = 4;
    localparam int CFG_DATA_BITS      = 64;

    localparam logic [19:0] DIST_CAP           = 20'd999999;
    localparam logic [15:0] CLEAR_BONUS_MIN    = 16'd34;
    localparam logic [6:0]  CLEAR_BONUS        = 7'd2;
    localparam logic [6:0]  RUN_MAX            = 7'd63;
    localparam logic [5:0]  STABLE_COUNT_RESET = 6'd3;

    localparam logic [2:0] CLASS_UNKNOWN = 3'd0;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_PRESET_BLUE   = 4'd0,
        REG_PRESET_YELLOW = 4'd1,
        REG_PRESET_GREEN  = 4'd2,
        REG_PRESET_RED    = 4'd3,
        REG_PRESET_BROWN  = 4'd4,
        REG_MAX_BEST      = 4'd5,
        REG_MIN_MARGIN    = 4'd6,
        REG_STABLE_COUNT  = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0] red_width;
        logic [15:0] green_width;
        logic [15:0] blue_width;
        logic [15:0] clear_width;
    } sample_t;

    typedef struct packed {
        logic [2:0]  sample_class;
        logic [19:0] best_distance;
        logic [19:0] second_distance;
        logic [19:0] margin;
        logic [4:0]  sample_number;
        logic [5:0]  run_length;
        logic        session_done;
        logic        stable_hit;
        logic [2:0]  final_class;
        logic [4:0]  leader_votes;
    } result_t;

    typedef struct packed {
        logic [NUM_PRESETS-1:0][63:0] preset;
        logic [19:0]                  max_best_distance;
        logic [19:0]                  min_margin;
        logic [5:0]                   stable_count;
    } cfg_t;

    // Classified item handed from the front to the back through the queue
    typedef struct packed {
        logic [2:0]  cls;
        logic [19:0] best;
        logic [19:0] second;
        logic [19:0] margin;
        logic        bonus;
    } cand_t;

endpackage

`default_nettype wire

// ===== rtl/core/scc_front.sv =====
// Front end: saturates channels, squares distances to the presets and picks a class.
// Uses scc_pkg; feeds the item queue.
`default_nettype none

module scc_front #(
    parameter int CHANNEL_BITS = scc_pkg::CHANNEL_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire scc_pkg::cfg_t  cfg,
    input  wire scc_pkg::sample_t sample,
    input  wire logic           sample_valid,
    output logic                sample_ready,
    output scc_pkg::cand_t      cand,
    output logic                cand_valid,
    input  wire logic           cand_ready
);

    localparam int CB       = CHANNEL_BITS;
    localparam int SQ_BITS  = 2 * CB;
    localparam int SUM_BITS = (2 * CB + 2 > 20) ? 2 * CB + 2 : 20;
    localparam logic [15:0] CH_MAX = 16'((1 << CB) - 1);
    localparam int NP = scc_pkg::NUM_PRESETS;
    localparam int NC = scc_pkg::SENSOR_CHANNELS;

    logic [NP-1:0][NC-1:0][CB-1:0]      diff_reg, diff_next;
    logic [NP-1:0][NC-1:0][SQ_BITS-1:0] sq_reg;
    logic [NP-1:0][19:0]                dist_reg;
    logic bonus_a_reg, bonus_b_reg, bonus_c_reg, bonus_next;
    logic valid_a_reg, valid_b_reg, valid_c_reg;
    logic advance;

    function automatic logic [CB-1:0] sat_ch(input logic [15:0] v);
        return (v > CH_MAX) ? CH_MAX[CB-1:0] : v[CB-1:0];
    endfunction

    // Whole pipe moves together; hold when the last stage cannot drain
    assign advance      = !valid_c_reg || cand_ready;
    assign sample_ready = advance;

    always_comb
    begin
        logic [NC-1:0][CB-1:0] ch;
        logic [CB-1:0] r;
        ch[0] = sat_ch(sample.red_width);
        ch[1] = sat_ch(sample.green_width);
        ch[2] = sat_ch(sample.blue_width);
        ch[3] = sat_ch(sample.clear_width);
        bonus_next = ({{(16-CB){1'b0}}, ch[3]} >= scc_pkg::CLEAR_BONUS_MIN);
        for (int p = 0; p < NP; p++)
        begin
            for (int c = 0; c < NC; c++)
            begin
                r = sat_ch(cfg.preset[p][16*c +: 16]);
                diff_next[p][c] = (ch[c] > r) ? ch[c] - r : r - ch[c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_a_reg <= sample_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            logic [SUM_BITS-1:0] sum;
            diff_reg    <= diff_next;
            bonus_a_reg <= bonus_next;
            bonus_b_reg <= bonus_a_reg;
            bonus_c_reg <= bonus_b_reg;
            for (int p = 0; p < NP; p++)
            begin
                for (int c = 0; c < NC; c++)
                begin
                    sq_reg[p][c] <= SQ_BITS'(diff_reg[p][c]) * SQ_BITS'(diff_reg[p][c]);
                end
                sum = SUM_BITS'(sq_reg[p][0]) + SUM_BITS'(sq_reg[p][1])
                    + SUM_BITS'(sq_reg[p][2]) + SUM_BITS'(sq_reg[p][3]);
                // Cap early: a distance at or above the cap never wins a slot
                dist_reg[p] <= (sum > SUM_BITS'(scc_pkg::DIST_CAP)) ?
                               scc_pkg::DIST_CAP : sum[19:0];
            end
        end
    end

    always_comb
    begin
        logic [19:0] best, second, mgn;
        logic [2:0]  bc;
        best   = scc_pkg::DIST_CAP;
        second = scc_pkg::DIST_CAP;
        bc     = scc_pkg::CLASS_UNKNOWN;
        // Earlier preset keeps a tie
        for (int p = 0; p < NP; p++)
        begin
            if (dist_reg[p] < best)
            begin
                second = best;
                best   = dist_reg[p];
                bc     = 3'(p + 1);
            end
            else if (dist_reg[p] < second)
            begin
                second = dist_reg[p];
            end
        end
        mgn = second - best;
        cand.best   = best;
        cand.second = second;
        cand.margin = mgn;
        cand.bonus  = bonus_c_reg;
        cand.cls    = (best > cfg.max_best_distance || mgn < cfg.min_margin) ?
                      scc_pkg::CLASS_UNKNOWN : bc;
    end

    assign cand_valid = valid_c_reg;

endmodule

`default_nettype wire

// ===== rtl/core/scc_fifo.sv =====
// Small item queue between the front and back ends.
// Generic width and depth; no package dependency.
`default_nettype none

module scc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             push_valid,
    output logic                  push_ready,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != CNT_BITS'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    function automatic logic [PTR_BITS-1:0] bump(input logic [PTR_BITS-1:0] p);
        return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_BITS'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/scc_back.sv =====
// Back end: session votes, run count, leader and session end; holds the result register.
// Uses scc_pkg; drains the item queue.
`default_nettype none

module scc_back #(
    parameter int SESSION_LENGTH = scc_pkg::SESSION_LENGTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire scc_pkg::cfg_t  cfg,
    input  wire scc_pkg::cand_t cand,
    input  wire logic           cand_valid,
    output logic                cand_ready,
    output scc_pkg::result_t    result,
    output logic                result_valid,
    input  wire logic           result_ready
);

    logic [4:0] vote_reg [scc_pkg::NUM_CLASSES];
    logic [5:0] run_reg;
    logic [2:0] prev_reg, leader_cls_reg;
    logic [4:0] leader_cnt_reg, samples_reg;
    logic       result_valid_reg;
    scc_pkg::result_t result_reg, result_next;

    logic       take;
    logic [4:0] vote_new, lc_new, num;
    logic [2:0] lcls_new;
    logic [5:0] run_new;
    logic       done;

    assign cand_ready   = !result_valid_reg || result_ready;
    assign take         = cand_valid && cand_ready;
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    always_comb
    begin
        logic [6:0] run_b, run_c;
        logic       stable, last;
        vote_new = vote_reg[cand.cls] + 5'd1;
        run_b = {1'b0, run_reg} + (cand.bonus ? scc_pkg::CLEAR_BONUS : 7'd0);
        // Class change drops the run and its bonus
        run_c = (cand.cls == prev_reg) ? run_b + 7'd1 : 7'd1;
        run_new = (run_c > scc_pkg::RUN_MAX) ? scc_pkg::RUN_MAX[5:0] : run_c[5:0];
        if (vote_new > leader_cnt_reg)
        begin
            lc_new   = vote_new;
            lcls_new = cand.cls;
        end
        else
        begin
            lc_new   = leader_cnt_reg;
            lcls_new = leader_cls_reg;
        end
        num    = samples_reg + 5'd1;
        stable = (run_new >= cfg.stable_count);
        last   = (num >= 5'(SESSION_LENGTH));
        done   = stable || last;

        result_next.sample_class    = cand.cls;
        result_next.best_distance   = cand.best;
        result_next.second_distance = cand.second;
        result_next.margin          = cand.margin;
        result_next.sample_number   = num;
        result_next.run_length      = run_new;
        result_next.session_done    = done;
        result_next.stable_hit      = stable;
        result_next.leader_votes    = lc_new;
        priority if (stable)
        begin
            result_next.final_class = cand.cls;
        end
        else if (last && ({1'b0, lc_new} >= cfg.stable_count))
        begin
            result_next.final_class = lcls_new;
        end
        else
        begin
            result_next.final_class = scc_pkg::CLASS_UNKNOWN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < scc_pkg::NUM_CLASSES; k++)
            begin
                vote_reg[k] <= '0;
            end
            run_reg          <= '0;
            prev_reg         <= scc_pkg::CLASS_UNKNOWN;
            leader_cls_reg   <= scc_pkg::CLASS_UNKNOWN;
            leader_cnt_reg   <= '0;
            samples_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            if (take)
            begin
                if (done)
                begin
                    // Restart the session
                    for (int k = 0; k < scc_pkg::NUM_CLASSES; k++)
                    begin
                        vote_reg[k] <= '0;
                    end
                    run_reg        <= '0;
                    prev_reg       <= scc_pkg::CLASS_UNKNOWN;
                    leader_cls_reg <= scc_pkg::CLASS_UNKNOWN;
                    leader_cnt_reg <= '0;
                    samples_reg    <= '0;
                end
                else
                begin
                    vote_reg[cand.cls] <= vote_new;
                    run_reg            <= run_new;
                    prev_reg           <= cand.cls;
                    leader_cls_reg     <= lcls_new;
                    leader_cnt_reg     <= lc_new;
                    samples_reg        <= num;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/stable_color_classifier.sv =====
// Top level of the stable color classifier: configuration registers, front, queue, back.
// Uses scc_pkg, scc_front, scc_fifo and scc_back.
//
//   channel   | handshake                    | payload
//   ----------+------------------------------+----------------------------
//   sample    | sample_valid / sample_ready  | scc_pkg::sample_t
//   result    | result_valid / result_ready  | scc_pkg::result_t
//   config    | cfg_write (no wait)          | cfg_index, cfg_data
//
// One item per cycle sustained while results are taken. From accept to result valid an
// item passes saturate/diff, square, sum, then classify into the queue and the session
// update into the result register. The three front stages move as one and hold while the
// queue is full; the back end holds while the result register waits to be taken.
// Reset clears the session state, the queue and the configuration to its defaults.
`default_nettype none

module stable_color_classifier #(
    parameter int SESSION_LENGTH = scc_pkg::SESSION_LENGTH_DEF,
    parameter int CHANNEL_BITS   = scc_pkg::CHANNEL_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write,
    input  wire logic [scc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [scc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  wire scc_pkg::sample_t                     sample,
    input  wire logic                                 sample_valid,
    output logic                                      sample_ready,
    output scc_pkg::result_t                          result,
    output logic                                      result_valid,
    input  wire logic                                 result_ready
);

    scc_pkg::cfg_t  cfg_reg;
    scc_pkg::cand_t front_cand, back_cand;
    logic           front_valid, front_ready, back_valid, back_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.preset            <= '0;
            cfg_reg.max_best_distance <= scc_pkg::DIST_CAP;
            cfg_reg.min_margin        <= '0;
            cfg_reg.stable_count      <= scc_pkg::STABLE_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (scc_pkg::cfg_reg_t'(cfg_index))
                scc_pkg::REG_PRESET_BLUE:   cfg_reg.preset[0] <= cfg_data;
                scc_pkg::REG_PRESET_YELLOW: cfg_reg.preset[1] <= cfg_data;
                scc_pkg::REG_PRESET_GREEN:  cfg_reg.preset[2] <= cfg_data;
                scc_pkg::REG_PRESET_RED:    cfg_reg.preset[3] <= cfg_data;
                scc_pkg::REG_PRESET_BROWN:  cfg_reg.preset[4] <= cfg_data;
                scc_pkg::REG_MAX_BEST:      cfg_reg.max_best_distance <= cfg_data[19:0];
                scc_pkg::REG_MIN_MARGIN:    cfg_reg.min_margin <= cfg_data[19:0];
                scc_pkg::REG_STABLE_COUNT:  cfg_reg.stable_count <= cfg_data[5:0];
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    scc_front #(
        .CHANNEL_BITS(CHANNEL_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sample       (sample),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .cand         (front_cand),
        .cand_valid   (front_valid),
        .cand_ready   (front_ready)
    );

    scc_fifo #(
        .WIDTH ($bits(scc_pkg::cand_t)),
        .DEPTH (scc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (front_cand),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_data   (back_cand),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    scc_back #(
        .SESSION_LENGTH(SESSION_LENGTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cand         (back_cand),
        .cand_valid   (back_valid),
        .cand_ready   (back_ready),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for stable_color_classifier: random and directed color samples,
// a vote tracker that predicts every result item, and random stalls on both channels.
// Depends on scc_pkg and the RTL under rtl/core.
`default_nettype none

module tb;
    import scc_pkg::*;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam int         SESSION_LEN   = SESSION_LENGTH_DEF;
    localparam int         CHAN_MAX      = (1 << CHANNEL_BITS_DEF) - 1;
    localparam int         MAX_WAIT      = 5;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         IDLE_LIMIT    = 1000;
    localparam int         PHASES        = 9;
    localparam int         PHASE_ITEMS   = 60;
    localparam logic [5:0] STABLE_TOP    = '1;
    localparam cfg_index_t REG_SPARE_FIRST = cfg_index_t'(REG_STABLE_COUNT + 1);
    localparam cfg_index_t REG_SPARE_LAST  = '1;

    class vote_tracker;
        logic [63:0]   presets [NUM_PRESETS];
        logic [19:0]   max_best;
        logic [19:0]   min_margin;
        logic [5:0]    stable_thr;

        logic [4:0]    votes [NUM_CLASSES];
        int unsigned   run_count;
        int unsigned   prev_cls;
        int unsigned   leader_cls;
        logic [4:0]    leader_cnt;
        logic [4:0]    taken;

        result_t       due_reports [$];
        int unsigned   errors;
        int unsigned   samples;
        int unsigned   sessions;
        int unsigned   stable_ends;
        int unsigned   vote_ends;

        function new();
            foreach (presets[p])
                presets[p] = '0;
            max_best   = DIST_CAP;
            min_margin = '0;
            stable_thr = STABLE_COUNT_RESET;
            clear_session();
        endfunction

        function void clear_session();
            foreach (votes[k])
                votes[k] = '0;
            run_count  = 0;
            prev_cls   = CLASS_UNKNOWN;
            leader_cls = CLASS_UNKNOWN;
            leader_cnt = '0;
            taken      = '0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [63:0] data);
            case (idx)
                REG_PRESET_BLUE, REG_PRESET_YELLOW, REG_PRESET_GREEN,
                REG_PRESET_RED, REG_PRESET_BROWN:
                    presets[idx] = data;
                REG_MAX_BEST:     max_best   = data[19:0];
                REG_MIN_MARGIN:   min_margin = data[19:0];
                REG_STABLE_COUNT: stable_thr = data[5:0];
                default:          ;
            endcase
        endfunction

        function void take_sample(sample_t s);
            longint unsigned ch [SENSOR_CHANNELS];
            longint unsigned ref_ch, diff, d, best, second;
            int unsigned     best_cls, cls, fin;
            bit              done, stable;
            result_t         r;
            ch[0] = s.red_width;
            ch[1] = s.green_width;
            ch[2] = s.blue_width;
            ch[3] = s.clear_width;
            best = DIST_CAP;
            second = DIST_CAP;
            best_cls = CLASS_UNKNOWN;
            for (int p = 0; p < NUM_PRESETS; p++)
            begin
                d = 0;
                for (int c = 0; c < SENSOR_CHANNELS; c++)
                begin
                    ref_ch = presets[p][16*c +: 16];
                    diff = (ch[c] > ref_ch) ? ch[c] - ref_ch : ref_ch - ch[c];
                    d += diff * diff;
                end
                // class codes follow preset order, one above the preset index
                if (d < best)
                begin
                    second = best;
                    best = d;
                    best_cls = p + 1;
                end
                else if (d < second)
                    second = d;
            end
            cls = (best > max_best || (second - best) < min_margin) ? CLASS_UNKNOWN : best_cls;

            if (ch[3] >= CLEAR_BONUS_MIN)
                run_count += CLEAR_BONUS;
            votes[cls] = votes[cls] + 1'b1;
            if (cls == prev_cls)
                run_count += 1;
            else
            begin
                // class change drops any bonus
                prev_cls = cls;
                run_count = 1;
            end
            if (run_count > RUN_MAX)
                run_count = RUN_MAX;
            if (votes[cls] > leader_cnt)
            begin
                leader_cnt = votes[cls];
                leader_cls = cls;
            end
            taken = taken + 1'b1;

            done = 1'b0;
            stable = 1'b0;
            fin = CLASS_UNKNOWN;
            if (run_count >= stable_thr)
            begin
                done = 1'b1;
                stable = 1'b1;
                fin = cls;
            end
            else if (taken >= SESSION_LEN)
            begin
                done = 1'b1;
                fin = (leader_cnt >= stable_thr) ? leader_cls : CLASS_UNKNOWN;
            end

            r.sample_class    = 3'(cls);
            r.best_distance   = 20'(best);
            r.second_distance = 20'(second);
            r.margin          = 20'(second - best);
            r.sample_number   = taken;
            r.run_length      = 6'(run_count);
            r.session_done    = done;
            r.stable_hit      = stable;
            r.final_class     = 3'(fin);
            r.leader_votes    = leader_cnt;
            due_reports.push_back(r);
            samples++;

            if (done)
            begin
                sessions++;
                if (stable)
                    stable_ends++;
                else if (fin != CLASS_UNKNOWN)
                    vote_ends++;
                clear_session();
            end
        endfunction

        function void cmp(string field, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void match_report(result_t got);
            result_t want;
            if (due_reports.size() == 0)
            begin
                $error("result item with no sample waiting (class %0d)", got.sample_class);
                errors++;
                return;
            end
            want = due_reports.pop_front();
            cmp("sample_class",    want.sample_class,    got.sample_class);
            cmp("best_distance",   want.best_distance,   got.best_distance);
            cmp("second_distance", want.second_distance, got.second_distance);
            cmp("margin",          want.margin,          got.margin);
            cmp("sample_number",   want.sample_number,   got.sample_number);
            cmp("run_length",      want.run_length,      got.run_length);
            cmp("session_done",    want.session_done,    got.session_done);
            cmp("stable_hit",      want.stable_hit,      got.stable_hit);
            cmp("final_class",     want.final_class,     got.final_class);
            cmp("leader_votes",    want.leader_votes,    got.leader_votes);
        endfunction

        function int unsigned pending();
            return due_reports.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write;
    cfg_index_t  cfg_index;
    logic [63:0] cfg_data;
    sample_t     sample;
    logic        sample_valid;
    logic        sample_ready;
    result_t     result;
    logic        result_valid;
    logic        result_ready;

    vote_tracker tracker;
    int unsigned cfg_writes;
    int unsigned stalled;
    int unsigned rx_wait;
    bit          rx_steady;
    bit          tx_steady;
    int unsigned streak_cls;
    int unsigned streak_left;
    int unsigned streak_spread;

    stable_color_classifier DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       (sample),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    always #6 clk = ~clk;

    function automatic logic [15:0] clamp16(int v);
        if (v < 0)
            return '0;
        if (v > CHAN_MAX)
            return '1;
        return v[15:0];
    endfunction

    function automatic sample_t mk(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                                   logic [15:0] c);
        sample_t s;
        s.red_width   = r;
        s.green_width = g;
        s.blue_width  = b;
        s.clear_width = c;
        return s;
    endfunction

    function automatic logic [63:0] pack_preset(logic [15:0] r, logic [15:0] g,
                                                logic [15:0] b, logic [15:0] c);
        return {c, b, g, r};
    endfunction

    function automatic sample_t near_preset(int unsigned p, int unsigned spread);
        logic [15:0] ch [SENSOR_CHANNELS];
        for (int c = 0; c < SENSOR_CHANNELS; c++)
            ch[c] = clamp16(int'(tracker.presets[p][16*c +: 16])
                            + int'($urandom_range(2 * spread, 0)) - int'(spread));
        return mk(ch[0], ch[1], ch[2], ch[3]);
    endfunction

    function automatic sample_t pick_sample();
        int unsigned roll;
        logic [3:0]  ends;
        roll = $urandom_range(99, 0);
        if (roll < 70)
        begin
            // runs of one color, tight or loose around its preset
            if (streak_left == 0)
            begin
                streak_cls = $urandom_range(NUM_PRESETS - 1, 0);
                streak_left = $urandom_range(8, 1);
                streak_spread = $urandom_range(1, 0) ? 20 : 300;
            end
            streak_left--;
            return near_preset(streak_cls, streak_spread);
        end
        if (roll < 85)
            return near_preset($urandom_range(NUM_PRESETS - 1, 0), 800);
        if (roll < 92)
        begin
            ends = 4'($urandom);
            return mk({16{ends[0]}}, {16{ends[1]}}, {16{ends[2]}}, {16{ends[3]}});
        end
        return sample_t'({$urandom, $urandom});
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [63:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        tracker.write_reg(idx, data);
        cfg_writes++;
    endtask

    // Lower valid, wait out every result, then let the pipeline go quiet.
    task automatic drain();
        sample_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_sample(input sample_t s);
        int unsigned gap;
        if ($urandom_range(39, 0) == 0)
            tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(MAX_WAIT, 0);
        if (gap != 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample <= s;
        sample_valid <= 1'b1;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        tracker.take_sample(s);
        // now and then hold off until the block has emptied
        if ($urandom_range(59, 0) == 0)
            drain();
    endtask

    task automatic run_directed();
        // all presets zero after reset: every distance ties, and blue wins unless the tie is at the cap
        send_sample(mk(0, 0, 0, 0));
        send_sample(mk('1, '1, '1, '1));
        send_sample(mk(0, 0, 0, CLEAR_BONUS_MIN - 1'b1));
        send_sample(mk(0, 0, 0, CLEAR_BONUS_MIN));
        drain();

        write_reg(REG_PRESET_BLUE,   pack_preset(1000, 1000, 1000, 40));
        write_reg(REG_PRESET_YELLOW, pack_preset(5000, 5000, 1000, 40));
        write_reg(REG_PRESET_GREEN,  pack_preset(1000, 5000, 1000, 10));
        write_reg(REG_PRESET_RED,    pack_preset(5000, 1000, 1000, 60));
        write_reg(REG_PRESET_BROWN,  pack_preset(3000, 2000, 1000, 20));
        write_reg(REG_MAX_BEST, DIST_CAP);
        write_reg(REG_MIN_MARGIN, '0);
        write_reg(REG_STABLE_COUNT, STABLE_TOP);
        cfg_write <= 1'b0;
        for (int p = 0; p < NUM_PRESETS; p++)
            send_sample(near_preset(p, 0));
        drain();

        // brown duplicates red: the tie goes to red, then a margin of one rejects it
        write_reg(REG_PRESET_BROWN, pack_preset(5000, 1000, 1000, 60));
        cfg_write <= 1'b0;
        send_sample(near_preset(3, 0));
        drain();
        write_reg(REG_MIN_MARGIN, 1);
        cfg_write <= 1'b0;
        send_sample(near_preset(3, 0));
        drain();

        // best distance right at and just past the limit
        write_reg(REG_MIN_MARGIN, '0);
        write_reg(REG_MAX_BEST, 100);
        cfg_write <= 1'b0;
        send_sample(mk(1010, 1000, 1000, 40));
        send_sample(mk(1011, 1000, 1000, 40));
        drain();

        // zero threshold closes the session on its first sample
        write_reg(REG_STABLE_COUNT, '0);
        cfg_write <= 1'b0;
        send_sample(near_preset(1, 0));
        drain();

        write_reg(REG_SPARE_FIRST, '1);
        write_reg(REG_SPARE_LAST, {$urandom, $urandom});
        write_reg(REG_MAX_BEST, DIST_CAP);
        write_reg(REG_STABLE_COUNT, STABLE_COUNT_RESET);
        cfg_write <= 1'b0;
        send_sample(near_preset(0, 0));
        send_sample(near_preset(0, 0));
        send_sample(near_preset(2, 0));
    endtask

    task automatic configure_phase(input int ph);
        logic [19:0] lim, mrg;
        logic [5:0]  thr;
        logic [63:0] v, prev_v;
        int          center [3];
        bit          clustered, low_clear;
        case (ph)
            0:
            begin
                lim = DIST_CAP;
                mrg = '0;
                thr = STABLE_COUNT_RESET;
            end
            1:
            begin
                lim = '0;
                mrg = '0;
                thr = STABLE_TOP;
            end
            2:
            begin
                lim = 20'($urandom_range(DIST_CAP, 0));
                mrg = DIST_CAP;
                thr = 1;
            end
            3:
            begin
                lim = DIST_CAP;
                mrg = 20'($urandom_range(20000, 0));
                thr = 10;
            end
            4:
            begin
                lim = 20'($urandom_range(DIST_CAP, 0));
                mrg = '0;
                thr = '0;
            end
            default:
            begin
                lim = $urandom_range(1, 0) ? DIST_CAP : 20'($urandom_range(DIST_CAP, 0));
                mrg = $urandom_range(1, 0) ? 20'd0 : 20'($urandom_range(100000, 0));
                thr = $urandom_range(3, 0) == 0 ? STABLE_TOP : 6'($urandom_range(20, 1));
            end
        endcase
        clustered = ph[0];
        low_clear = ph[1];
        prev_v = '0;
        for (int c = 0; c < 3; c++)
            center[c] = $urandom_range(CHAN_MAX, 0);
        for (int p = 0; p < NUM_PRESETS; p++)
        begin
            v = '0;
            for (int c = 0; c < 3; c++)
                v[16*c +: 16] = clustered
                    ? clamp16(center[c] + int'($urandom_range(800, 0)) - 400)
                    : 16'($urandom_range(CHAN_MAX, 0));
            v[63:48] = 16'($urandom_range(low_clear ? 30 : 100, 0));
            if (ph == PHASES - 1 && p == 0)
                v = '1;
            if (ph == PHASES - 1 && p == NUM_PRESETS - 1)
                v = '0;
            // two presets equal: ties in both best and second place
            if (ph == 6 && p == NUM_PRESETS - 1)
                v = prev_v;
            write_reg(cfg_index_t'(REG_PRESET_BLUE + p), v);
            prev_v = v;
        end
        write_reg(REG_MAX_BEST, {32'($urandom), 12'($urandom), lim});
        write_reg(REG_MIN_MARGIN, {32'($urandom), 12'($urandom), mrg});
        write_reg(REG_STABLE_COUNT, {32'($urandom), 26'($urandom), thr});
        if ($urandom_range(1, 0) == 0)
            write_reg(cfg_index_t'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                      {$urandom, $urandom});
        cfg_write <= 1'b0;
        streak_left = 0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                tracker.match_report(result);
                if ($urandom_range(29, 0) == 0)
                    rx_steady = !rx_steady;
                rx_wait = rx_steady ? 0 : $urandom_range(MAX_WAIT, 0);
                if (rx_wait != 0)
                    result_ready <= 1'b0;
            end
            else if (!result_ready)
            begin
                if (rx_wait != 0)
                    rx_wait--;
                if (rx_wait == 0)
                    result_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && sample_ready) || (result_valid && result_ready))
                stalled = 0;
            else
                stalled++;
            if (stalled >= IDLE_LIMIT)
            begin
                $display("tb: no item moved for %0d cycles", IDLE_LIMIT);
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        tracker = new();
        cfg_writes = 0;
        stalled = 0;
        rx_wait = 0;
        streak_left = 0;
        rst_n        <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        sample       <= '0;
        sample_valid <= 1'b0;
        result_ready <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            configure_phase(ph);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_sample(pick_sample());
        end
        drain();

        $display("tb: %0d samples, %0d sessions closed (%0d on a run, %0d on votes)",
                 tracker.samples, tracker.sessions, tracker.stable_ends, tracker.vote_ends);
        $display("tb: %0d register writes over %0d settings", cfg_writes, PHASES + 1);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
